FILE: design/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the order book RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clk edge, masked while rst_n is low.
`define LOB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising clk edge, reset included.
`define LOB_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/lob_pkg.sv
// ---------------------------------------------------------------------------
// lob_pkg
// Types and constants shared by the order book modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lob_pkg;

    localparam int ORDER_SLOTS_DEF = 4096;   // must be a power of two
    localparam int LEVEL_DEPTH_DEF = 64;
    localparam int PROBE_LIMIT_DEF = 8;
    localparam int QUEUE_DEPTH     = 2;      // front-to-back command queue

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_NOREF = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    typedef enum logic [1:0] {
        OP_ADD  = 2'd0,
        OP_EXEC = 2'd1,
        OP_DEL  = 2'd2,
        OP_REPL = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PROBE,
        ST_LVL,
        ST_LVL_WAIT,
        ST_DONE
    } bk_state_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [63:0] ref_id;
        logic [63:0] replacement_id;
        logic        sell_side;
        logic [31:0] share_count;
        logic [31:0] limit_price;
        logic [15:0] stock_tag;
    } msg_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] top_bid_price;
        logic [31:0] top_bid_volume;
        logic [31:0] top_ask_price;
        logic [31:0] top_ask_volume;
        logic [6:0]  bid_level_count;
        logic [6:0]  ask_level_count;
    } res_t;

    typedef struct packed {
        op_t         op;
        logic [63:0] ref_id;
        logic [63:0] replacement_id;
        logic        sell_side;
        logic [31:0] share_count;
        logic [31:0] limit_price;
        logic [15:0] stock_tag;
    } cmd_t;

    typedef struct packed {
        logic pop;
        logic clearing;
    } bk_ctl_t;

    typedef struct packed {
        logic        valid;
        logic [63:0] ref_id;
        logic [31:0] shares;
        logic [31:0] price;
        logic        is_sell;
        logic [15:0] tag;
    } slot_entry_t;

    typedef struct packed {
        logic        start;
        logic        is_add;
        logic [31:0] price;
        logic [31:0] shares;
    } lvl_cmd_t;

    typedef struct packed {
        logic        ok;
        logic [31:0] top_price;
        logic [31:0] top_volume;
    } lvl_stat_t;

endpackage

`default_nettype wire

FILE: design/lob_front.sv
// ---------------------------------------------------------------------------
// lob_front
// Input side: decodes each message and queues it for the back end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lob_front
    import lob_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    msg_valid,
    input  wire msg_t    msg,
    output logic         msg_stall,
    output logic         cmd_valid,
    output cmd_t         cmd,
    input  wire bk_ctl_t bk
);

    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    cmd_t          q_reg [QUEUE_DEPTH];
    logic [QW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QW:0]   cnt_reg;
    cmd_t          dec;
    logic          push;
    logic          full;

    always_comb
    begin
        dec.ref_id         = msg.ref_id;
        dec.replacement_id = msg.replacement_id;
        dec.sell_side      = msg.sell_side;
        dec.share_count    = msg.share_count;
        dec.limit_price    = msg.limit_price;
        dec.stock_tag      = msg.stock_tag;
        unique case (msg.mode)
            OP_ADD:  dec.op = OP_ADD;
            OP_EXEC: dec.op = OP_EXEC;
            OP_DEL:  dec.op = OP_DEL;
            default: dec.op = OP_REPL;
        endcase
    end

    assign full      = (cnt_reg == (QW+1)'(QUEUE_DEPTH));
    assign msg_stall = full || bk.clearing;
    assign push      = msg_valid && !msg_stall;
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (bk.pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (QW+1)'(push) - (QW+1)'(bk.pop);
        end
    end

`include "assert_macros.svh"

    `LOB_ASSERT(a_pop_nonempty, bk.pop |-> cnt_reg != '0, "pop from empty queue")
    `LOB_ASSERT(a_no_take_clear, bk.clearing |-> !push, "message taken during clear pass")

endmodule

`default_nettype wire

FILE: design/lob_levels.sv
// ---------------------------------------------------------------------------
// lob_levels
// One side of the book: sorted price levels with per-level volume.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lob_levels
    import lob_pkg::*;
#(
    parameter int DEPTH = LEVEL_DEPTH_DEF,
    parameter bit DESC  = 1'b1,
    localparam int CW   = $clog2(DEPTH + 1)
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire lvl_cmd_t cmd,
    output lvl_stat_t     stat,
    output logic [CW-1:0] count
);

    logic [31:0]      price_reg [DEPTH];
    logic [31:0]      vol_reg   [DEPTH];
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic [DEPTH-1:0] match_reg, better_reg, le_reg;
    logic [DEPTH-1:0] match_c, better_c, le_c;
    logic             add_reg;
    logic [31:0]      price_q, shares_q;
    logic             hit, hit_le, full;

    // Compare stage: every live entry against the incoming price.
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            match_c[i]  = (CW'(i) < cnt_reg) && (price_reg[i] == cmd.price);
            better_c[i] = (CW'(i) < cnt_reg) &&
                          (DESC ? (price_reg[i] > cmd.price) : (price_reg[i] < cmd.price));
            le_c[i]     = (vol_reg[i] <= cmd.shares);
        end
    end

    assign hit    = |match_reg;
    assign hit_le = |(match_reg & le_reg);
    assign full   = (cnt_reg >= CW'(DEPTH));

    // Apply stage: each entry picks its own, its neighbor's or the new value.
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_ent
        localparam int UP     = (g < DEPTH - 1) ? g + 1 : g;
        localparam int DN     = (g > 0) ? g - 1 : g;
        localparam bit HAS_UP = (g < DEPTH - 1);
        localparam bit HAS_DN = (g > 0);
        logic [31:0] p_n, v_n;

        always_comb
        begin
            p_n = price_reg[g];
            v_n = vol_reg[g];
            if (busy_reg)
            begin
                if (add_reg)
                begin
                    if (hit)
                    begin
                        if (match_reg[g])
                        begin
                            v_n = vol_reg[g] + shares_q;
                        end
                    end
                    else if (!full)
                    begin
                        if (HAS_DN && !better_reg[DN])
                        begin
                            p_n = price_reg[DN];
                            v_n = vol_reg[DN];
                        end
                        else if (!better_reg[g])
                        begin
                            p_n = price_q;
                            v_n = shares_q;
                        end
                    end
                end
                else if (hit)
                begin
                    if (hit_le)
                    begin
                        if (HAS_UP && !better_reg[g])
                        begin
                            p_n = price_reg[UP];
                            v_n = vol_reg[UP];
                        end
                    end
                    else if (match_reg[g])
                    begin
                        v_n = vol_reg[g] - shares_q;
                    end
                end
            end
        end

        always_ff @(posedge clk)
        begin
            price_reg[g] <= p_n;
            vol_reg[g]   <= v_n;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            match_reg  <= match_c;
            better_reg <= better_c;
            le_reg     <= le_c;
            add_reg    <= cmd.is_add;
            price_q    <= cmd.price;
            shares_q   <= cmd.shares;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= cmd.start;
            if (busy_reg)
            begin
                if (add_reg && !hit && !full)
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
                else if (!add_reg && hit_le)
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    assign stat.ok         = !add_reg || hit || !full;
    assign stat.top_price  = (cnt_reg != '0) ? price_reg[0] : 32'd0;
    assign stat.top_volume = (cnt_reg != '0) ? vol_reg[0] : 32'd0;
    assign count           = cnt_reg;

`include "assert_macros.svh"

    `LOB_ASSERT_ALWAYS(a_cnt_range, cnt_reg <= CW'(DEPTH), "level count above depth")
    `LOB_ASSERT(a_one_apply, busy_reg |=> !busy_reg, "level update spans two cycles")

endmodule

`default_nettype wire

FILE: design/lob_back.sv
// ---------------------------------------------------------------------------
// lob_back
// Execution side: order table probe, slot update, level update, result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lob_back
    import lob_pkg::*;
#(
    parameter int ORDER_SLOTS = ORDER_SLOTS_DEF,
    parameter int LEVEL_DEPTH = LEVEL_DEPTH_DEF,
    parameter int PROBE_LIMIT = PROBE_LIMIT_DEF
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  cmd_valid,
    input  wire cmd_t  cmd,
    output bk_ctl_t    bk,
    output logic       res_valid,
    output res_t       res,
    input  wire logic  res_stall
);

    localparam int AW = $clog2(ORDER_SLOTS);
    localparam int PW = $clog2(PROBE_LIMIT + 1);
    localparam int CW = $clog2(LEVEL_DEPTH + 1);

    // order table
    slot_entry_t mem [ORDER_SLOTS];
    slot_entry_t rd_q, wr_data;
    logic        wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_q <= mem[rd_addr];
        end
    end

    bk_state_t     state_reg, state_next;
    op_t           op_reg, op_next;
    logic          add_phase_reg, add_phase_next;
    logic [63:0]   probe_ref_reg, probe_ref_next;
    logic [63:0]   new_ref_reg, new_ref_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [PW-1:0] n_reg, n_next;
    logic [31:0]   shares_reg, shares_next;
    logic [31:0]   price_reg, price_next;
    logic          add_sell_reg, add_sell_next;
    logic [15:0]   add_tag_reg, add_tag_next;
    logic          lvl_sell_reg, lvl_sell_next;
    logic          lvl_add_reg, lvl_add_next;
    logic [31:0]   lvl_price_reg, lvl_price_next;
    logic [31:0]   lvl_shares_reg, lvl_shares_next;
    logic [1:0]    status_reg, status_next;
    logic [AW-1:0] clr_idx_reg, clr_idx_next;
    logic          out_valid_reg, out_valid_next;
    res_t          out_reg, out_next;

    logic          lvl_go;
    lvl_cmd_t      bid_cmd, ask_cmd;
    lvl_stat_t     bid_stat, ask_stat;
    logic [CW-1:0] bid_cnt, ask_cnt;
    logic          ref_eq, hit, cont, adding, lvl_ok;

    assign ref_eq = (rd_q.ref_id == probe_ref_reg);
    assign hit    = rd_q.valid && ref_eq;
    assign cont   = rd_q.valid && !ref_eq && (n_reg < PW'(PROBE_LIMIT));
    assign adding = (op_reg == OP_ADD) || ((op_reg == OP_REPL) && add_phase_reg);
    assign lvl_ok = lvl_sell_reg ? ask_stat.ok : bid_stat.ok;

    always_comb
    begin
        bid_cmd.start  = lvl_go && !lvl_sell_reg;
        ask_cmd.start  = lvl_go && lvl_sell_reg;
        bid_cmd.is_add = lvl_add_reg;
        ask_cmd.is_add = lvl_add_reg;
        bid_cmd.price  = lvl_price_reg;
        ask_cmd.price  = lvl_price_reg;
        bid_cmd.shares = lvl_shares_reg;
        ask_cmd.shares = lvl_shares_reg;
    end

    lob_levels #(.DEPTH(LEVEL_DEPTH), .DESC(1'b1)) u_bids
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (bid_cmd),
        .stat  (bid_stat),
        .count (bid_cnt)
    );

    lob_levels #(.DEPTH(LEVEL_DEPTH), .DESC(1'b0)) u_asks
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (ask_cmd),
        .stat  (ask_stat),
        .count (ask_cnt)
    );

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        add_phase_next  = add_phase_reg;
        probe_ref_next  = probe_ref_reg;
        new_ref_next    = new_ref_reg;
        idx_next        = idx_reg;
        n_next          = n_reg;
        shares_next     = shares_reg;
        price_next      = price_reg;
        add_sell_next   = add_sell_reg;
        add_tag_next    = add_tag_reg;
        lvl_sell_next   = lvl_sell_reg;
        lvl_add_next    = lvl_add_reg;
        lvl_price_next  = lvl_price_reg;
        lvl_shares_next = lvl_shares_reg;
        status_next     = status_reg;
        clr_idx_next    = clr_idx_reg;
        out_valid_next  = out_valid_reg && res_stall;
        out_next        = out_reg;
        wr_en           = 1'b0;
        wr_addr         = idx_reg;
        wr_data         = rd_q;
        rd_en           = 1'b0;
        rd_addr         = idx_reg;
        lvl_go          = 1'b0;
        bk.pop          = 1'b0;
        bk.clearing     = (state_reg == ST_CLEAR);

        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en        = 1'b1;
                wr_addr      = clr_idx_reg;
                wr_data      = '0;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == AW'(ORDER_SLOTS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    bk.pop         = 1'b1;
                    op_next        = cmd.op;
                    add_phase_next = 1'b0;
                    probe_ref_next = cmd.ref_id;
                    new_ref_next   = cmd.replacement_id;
                    idx_next       = cmd.ref_id[AW-1:0];
                    n_next         = '0;
                    shares_next    = cmd.share_count;
                    price_next     = cmd.limit_price;
                    add_sell_next  = cmd.sell_side;
                    add_tag_next   = cmd.stock_tag;
                    status_next    = STAT_OK;
                    rd_en          = 1'b1;
                    rd_addr        = cmd.ref_id[AW-1:0];
                    state_next     = ST_PROBE;
                end
            end

            ST_PROBE:
            begin
                if (cont)
                begin
                    idx_next = idx_reg + 1'b1;
                    n_next   = n_reg + 1'b1;
                    rd_en    = 1'b1;
                    rd_addr  = idx_reg + 1'b1;
                end
                else if (adding)
                begin
                    wr_en           = 1'b1;
                    wr_data.valid   = 1'b1;
                    wr_data.ref_id  = probe_ref_reg;
                    wr_data.shares  = shares_reg;
                    wr_data.price   = price_reg;
                    wr_data.is_sell = add_sell_reg;
                    wr_data.tag     = add_tag_reg;
                    lvl_sell_next   = add_sell_reg;
                    lvl_add_next    = 1'b1;
                    lvl_price_next  = price_reg;
                    lvl_shares_next = shares_reg;
                    state_next      = ST_LVL;
                end
                else if (!hit)
                begin
                    status_next = STAT_NOREF;
                    state_next  = ST_DONE;
                end
                else
                begin
                    wr_en          = 1'b1;
                    lvl_sell_next  = rd_q.is_sell;
                    lvl_add_next   = 1'b0;
                    lvl_price_next = rd_q.price;
                    if (op_reg == OP_EXEC)
                    begin
                        lvl_shares_next = shares_reg;
                        if (rd_q.shares <= shares_reg)
                        begin
                            wr_data.valid = 1'b0;
                        end
                        else
                        begin
                            wr_data.shares = rd_q.shares - shares_reg;
                        end
                    end
                    else
                    begin
                        lvl_shares_next = rd_q.shares;
                        wr_data.valid   = 1'b0;
                        add_sell_next   = rd_q.is_sell;
                        add_tag_next    = rd_q.tag;
                    end
                    state_next = ST_LVL;
                end
            end

            ST_LVL:
            begin
                lvl_go     = 1'b1;
                state_next = ST_LVL_WAIT;
            end

            ST_LVL_WAIT:
            begin
                // level side applies its update at the end of this cycle
                if (lvl_add_reg)
                begin
                    status_next = lvl_ok ? STAT_OK : STAT_FULL;
                    state_next  = ST_DONE;
                end
                else if (op_reg == OP_REPL)
                begin
                    add_phase_next = 1'b1;
                    probe_ref_next = new_ref_reg;
                    idx_next       = new_ref_reg[AW-1:0];
                    n_next         = '0;
                    rd_en          = 1'b1;
                    rd_addr        = new_ref_reg[AW-1:0];
                    state_next     = ST_PROBE;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || !res_stall)
                begin
                    out_valid_next           = 1'b1;
                    out_next.status          = status_reg;
                    out_next.top_bid_price   = bid_stat.top_price;
                    out_next.top_bid_volume  = bid_stat.top_volume;
                    out_next.top_ask_price   = ask_stat.top_price;
                    out_next.top_ask_volume  = ask_stat.top_volume;
                    out_next.bid_level_count = 7'(bid_cnt);
                    out_next.ask_level_count = 7'(ask_cnt);
                    state_next               = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        probe_ref_reg  <= probe_ref_next;
        new_ref_reg    <= new_ref_next;
        idx_reg        <= idx_next;
        n_reg          <= n_next;
        shares_reg     <= shares_next;
        price_reg      <= price_next;
        add_sell_reg   <= add_sell_next;
        add_tag_reg    <= add_tag_next;
        lvl_sell_reg   <= lvl_sell_next;
        lvl_add_reg    <= lvl_add_next;
        lvl_price_reg  <= lvl_price_next;
        lvl_shares_reg <= lvl_shares_next;
        status_reg     <= status_next;
        out_reg        <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            add_phase_reg <= 1'b0;
            clr_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            add_phase_reg <= add_phase_next;
            clr_idx_reg   <= clr_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

`include "assert_macros.svh"

    `LOB_ASSERT(a_clear_no_result, state_reg == ST_CLEAR |-> !out_valid_reg, "result during clear")
    `LOB_ASSERT(a_probe_bound, state_reg == ST_PROBE |-> n_reg <= PW'(PROBE_LIMIT), "probe overrun")

endmodule

`default_nettype wire

FILE: design/limit_order_book_unit.sv
// ---------------------------------------------------------------------------
// limit_order_book_unit
// Hashed order table with sorted bid/ask price levels; top of book per message.
// ---------------------------------------------------------------------------
//   channel  | signals                 | transfer when
//   msg      | msg_valid, msg_stall    | msg_valid && !msg_stall
//   res      | res_valid, res_stall    | res_valid && !res_stall
//
// In the back end a message takes P table probes (1 to PROBE_LIMIT+1,
// one memory read each), then a level update and the result; an unknown
// reference skips the level update. Replace runs the probe and level
// update twice. Level updates run a compare step, then an apply step.
// After reset a clear pass over all ORDER_SLOTS entries empties the order table;
// msg_stall stays high during it. A two-entry queue keeps taking messages
// while the back end works or a result waits on res_stall, until it is full.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module limit_order_book_unit
    import lob_pkg::*;
#(
    parameter int ORDER_SLOTS = ORDER_SLOTS_DEF,   // power of two
    parameter int LEVEL_DEPTH = LEVEL_DEPTH_DEF,
    parameter int PROBE_LIMIT = PROBE_LIMIT_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic msg_valid,
    output logic      msg_stall,
    input  wire msg_t msg,
    output logic      res_valid,
    input  wire logic res_stall,
    output res_t      res
);

    // front to back: decoded command, back to front: pop and clear status
    logic    cmd_valid;
    cmd_t    cmd;
    bk_ctl_t bk;

    lob_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg_valid (msg_valid),
        .msg       (msg),
        .msg_stall (msg_stall),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .bk        (bk)
    );

    lob_back #(
        .ORDER_SLOTS (ORDER_SLOTS),
        .LEVEL_DEPTH (LEVEL_DEPTH),
        .PROBE_LIMIT (PROBE_LIMIT)
    ) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .bk        (bk),
        .res_valid (res_valid),
        .res       (res),
        .res_stall (res_stall)
    );

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Order book test: directed and random order messages are checked against a
// behavioral book model; top-of-book results are compared per transfer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import lob_pkg::*;

    localparam int SLOTS = 4096;
    localparam int DEPTH = 64;
    localparam int PROBES = 8;
    localparam int WATCHDOG = 20000;   // covers the clear pass after reset
    localparam int MSG_W = $bits(msg_t);

    logic clk;
    logic rst_n;
    logic msg_valid;
    logic msg_stall;
    msg_t msg;
    logic res_valid;
    logic res_stall;
    res_t res;

    limit_order_book_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg_valid (msg_valid),
        .msg_stall (msg_stall),
        .msg       (msg),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    // book model state
    bit          bk_valid [SLOTS];
    logic [63:0] bk_ref   [SLOTS];
    logic [31:0] bk_shares[SLOTS];
    logic [31:0] bk_price [SLOTS];
    logic        bk_sell  [SLOTS];
    logic [15:0] bk_tag   [SLOTS];
    logic [31:0] lvl_px  [2][DEPTH];   // index 0 bids, 1 asks
    logic [31:0] lvl_vol [2][DEPTH];
    int          lvl_cnt [2];

    res_t        top_of_book_q[$];
    logic [63:0] live_refs[$];         // references most likely still resting
    int          errors;
    int          idle_cycles;
    bit          quiet;                // no idling in the last part

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int probe_slot(logic [63:0] r);
        int idx;
        int n;
        idx = int'(r % SLOTS);
        n = 0;
        while (bk_valid[idx] && bk_ref[idx] != r && n < PROBES)
        begin
            idx = (idx + 1) % SLOTS;
            n++;
        end
        return idx;
    endfunction

    function automatic bit level_insert(int s, logic [31:0] px, logic [31:0] sh);
        int pos;
        pos = 0;
        for (int i = 0; i < lvl_cnt[s]; i++)
            if (lvl_px[s][i] == px)
            begin
                lvl_vol[s][i] += sh;
                return 1'b1;
            end
        if (lvl_cnt[s] >= DEPTH)
            return 1'b0;
        while (pos < lvl_cnt[s] && (s == 0 ? lvl_px[s][pos] > px : lvl_px[s][pos] < px))
            pos++;
        for (int i = lvl_cnt[s]; i > pos; i--)
        begin
            lvl_px[s][i] = lvl_px[s][i-1];
            lvl_vol[s][i] = lvl_vol[s][i-1];
        end
        lvl_px[s][pos] = px;
        lvl_vol[s][pos] = sh;
        lvl_cnt[s]++;
        return 1'b1;
    endfunction

    function automatic void level_reduce(int s, logic [31:0] px, logic [31:0] sh);
        for (int i = 0; i < lvl_cnt[s]; i++)
            if (lvl_px[s][i] == px)
            begin
                if (lvl_vol[s][i] <= sh)
                begin
                    for (int j = i; j + 1 < lvl_cnt[s]; j++)
                    begin
                        lvl_px[s][j] = lvl_px[s][j+1];
                        lvl_vol[s][j] = lvl_vol[s][j+1];
                    end
                    lvl_cnt[s]--;
                end
                else
                    lvl_vol[s][i] -= sh;
                return;
            end
    endfunction

    function automatic logic [1:0] book_add(logic [63:0] r, logic sl, logic [31:0] sh,
                                            logic [31:0] px, logic [15:0] tg);
        int idx;
        idx = probe_slot(r);
        bk_valid[idx] = 1'b1;
        bk_ref[idx] = r;
        bk_shares[idx] = sh;
        bk_price[idx] = px;
        bk_sell[idx] = sl;
        bk_tag[idx] = tg;
        return level_insert(sl, px, sh) ? STAT_OK : STAT_FULL;
    endfunction

    // Apply one message to the model and return the top of book after it.
    function automatic res_t apply_message(msg_t m);
        res_t r;
        int idx;
        logic sl;
        logic [15:0] tg;
        r.status = STAT_OK;
        if (op_t'(m.mode) == OP_ADD)
            r.status = book_add(m.ref_id, m.sell_side, m.share_count, m.limit_price,
                                m.stock_tag);
        else
        begin
            idx = probe_slot(m.ref_id);
            if (!(bk_valid[idx] && bk_ref[idx] == m.ref_id))
                r.status = STAT_NOREF;
            else if (op_t'(m.mode) == OP_EXEC)
            begin
                level_reduce(bk_sell[idx], bk_price[idx], m.share_count);
                if (bk_shares[idx] <= m.share_count)
                    bk_valid[idx] = 1'b0;
                else
                    bk_shares[idx] -= m.share_count;
            end
            else
            begin
                sl = bk_sell[idx];
                tg = bk_tag[idx];
                level_reduce(sl, bk_price[idx], bk_shares[idx]);
                bk_valid[idx] = 1'b0;
                if (op_t'(m.mode) == OP_REPL)
                    r.status = book_add(m.replacement_id, sl, m.share_count,
                                        m.limit_price, tg);
            end
        end
        r.top_bid_price   = lvl_cnt[0] > 0 ? lvl_px[0][0] : 32'd0;
        r.top_bid_volume  = lvl_cnt[0] > 0 ? lvl_vol[0][0] : 32'd0;
        r.top_ask_price   = lvl_cnt[1] > 0 ? lvl_px[1][0] : 32'd0;
        r.top_ask_volume  = lvl_cnt[1] > 0 ? lvl_vol[1][0] : 32'd0;
        r.bid_level_count = 7'(lvl_cnt[0]);
        r.ask_level_count = 7'(lvl_cnt[1]);
        return r;
    endfunction

    // Send one message: random gap, then hold until the transfer happens.
    // Valid stays high into the next call and drops only for an idle gap.
    task automatic send_msg(msg_t m);
        if (!quiet && $urandom_range(3) == 0)
        begin
            msg_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        msg_valid <= 1'b1;
        msg <= m;
        @(posedge clk);
        while (msg_stall)
            @(posedge clk);
        top_of_book_q.push_back(apply_message(m));
        if (op_t'(m.mode) == OP_ADD)
            live_refs.push_back(m.ref_id);
        else if (op_t'(m.mode) == OP_REPL)
            live_refs.push_back(m.replacement_id);
        if (live_refs.size() > 200)
            void'(live_refs.pop_front());
    endtask

    function automatic msg_t make_msg(op_t op, logic [63:0] r, logic [63:0] nr, logic sl,
                                      logic [31:0] sh, logic [31:0] px, logic [15:0] tg);
        msg_t m;
        m.mode = op;
        m.ref_id = r;
        m.replacement_id = nr;
        m.sell_side = sl;
        m.share_count = sh;
        m.limit_price = px;
        m.stock_tag = tg;
        return m;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Result checker.
    always @(posedge clk)
    begin
        res_t exp_r;
        if (rst_n && res_valid && !res_stall)
        begin
            if (top_of_book_q.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, res);
                errors++;
            end
            else
            begin
                exp_r = top_of_book_q.pop_front();
                if (res.status !== exp_r.status)
                    $display("%0t: status exp %0d got %0d", $time, exp_r.status, res.status);
                if (res.top_bid_price !== exp_r.top_bid_price)
                    $display("%0t: bid px exp %0d got %0d", $time,
                             exp_r.top_bid_price, res.top_bid_price);
                if (res.top_bid_volume !== exp_r.top_bid_volume)
                    $display("%0t: bid vol exp %0d got %0d", $time,
                             exp_r.top_bid_volume, res.top_bid_volume);
                if (res.top_ask_price !== exp_r.top_ask_price)
                    $display("%0t: ask px exp %0d got %0d", $time,
                             exp_r.top_ask_price, res.top_ask_price);
                if (res.top_ask_volume !== exp_r.top_ask_volume)
                    $display("%0t: ask vol exp %0d got %0d", $time,
                             exp_r.top_ask_volume, res.top_ask_volume);
                if (res.bid_level_count !== exp_r.bid_level_count)
                    $display("%0t: bid lvls exp %0d got %0d", $time,
                             exp_r.bid_level_count, res.bid_level_count);
                if (res.ask_level_count !== exp_r.ask_level_count)
                    $display("%0t: ask lvls exp %0d got %0d", $time,
                             exp_r.ask_level_count, res.ask_level_count);
                if (res !== exp_r)
                    errors++;
            end
        end
    end

    // Random stall bursts on the result side.
    initial
    begin
        res_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!quiet && $urandom_range(4) == 0)
            begin
                res_stall <= 1'b1;
                repeat ($urandom_range(1, 7)) @(posedge clk);
                res_stall <= 1'b0;
            end
        end
    end

    // Watchdog: cycles without any transfer.
    always @(posedge clk)
    begin
        if ((msg_valid && !msg_stall) || (res_valid && !res_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Extremes of fields, every op, not-found, overwrite on probe failure,
    // add under a live reference, wrap of level volume, execute to zero.
    task automatic test_directed();
        send_msg(make_msg(OP_EXEC, 64'd5, 0, 0, 1, 0, 0));             // not found
        send_msg(make_msg(OP_ADD, 64'd0, 0, 0, 32'hFFFF_FFFF, 32'd0, 16'hFFFF));
        send_msg(make_msg(OP_ADD, '1, '1, 1, 32'd0, 32'hFFFF_FFFF, 16'h0));
        send_msg(make_msg(OP_ADD, 64'd1, 0, 0, 32'd2, 32'd0, 16'h1)); // volume wraps
        send_msg(make_msg(OP_ADD, 64'd0, 0, 1, 32'd7, 32'd100, 16'h2)); // live ref again
        send_msg(make_msg(OP_EXEC, 64'd1, 0, 0, 32'd2, 0, 0));
        send_msg(make_msg(OP_EXEC, '1, 0, 0, 32'hFFFF_FFFF, 0, 0));
        send_msg(make_msg(OP_DEL, 64'd0, 0, 0, 0, 0, 0));
        send_msg(make_msg(OP_REPL, 64'd1, 64'd2, 1, 5, 50, 0));
        send_msg(make_msg(OP_REPL, 64'd2, '1, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1));
        send_msg(make_msg(OP_DEL, 64'd77, 0, 0, 0, 0, 0));
        // same home slot: fill the probe window and overflow it
        for (int i = 0; i <= PROBES + 1; i++)
            send_msg(make_msg(OP_ADD, 64'(i * SLOTS + 9), 0, i[0], 10, 32'(200 + i), 16'(i)));
        send_msg(make_msg(OP_EXEC, 64'(3 * SLOTS + 9), 0, 0, 4, 0, 0));
        send_msg(make_msg(OP_DEL, 64'(9), 0, 0, 0, 0, 0));
    endtask

    // Fill the bid side past its depth to reach the full status.
    task automatic test_level_full();
        for (int i = 0; i < DEPTH + 3; i++)
            send_msg(make_msg(OP_ADD, 64'(1000 + i), 0, 0, 32'(i + 1), 32'(5000 + 7 * i), 0));
        send_msg(make_msg(OP_REPL, 64'd1000, 64'd2000, 0, 3, 32'd1, 0));
        for (int i = 0; i < DEPTH + 3; i++)
            send_msg(make_msg(OP_DEL, 64'(1000 + i), 0, 0, 0, 0, 0));
    endtask

    task automatic test_random(int count);
        msg_t m;
        int k;
        for (int n = 0; n < count; n++)
        begin
            m = msg_t'(MSG_W'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                               $urandom(), $urandom()}));
            k = $urandom_range(99);
            if (k < 45)
            begin
                // small ranges keep prices on shared levels and refs colliding
                m.mode = OP_ADD;
                if (k < 38)
                begin
                    m.ref_id = 64'($urandom_range(400)) * (k < 8 ? SLOTS : 1) + 64'(k);
                    m.limit_price = 32'(1000 + $urandom_range(80));
                    m.share_count = 32'($urandom_range(1, 500));
                end
            end
            else if (k < 95 && live_refs.size() > 0)
            begin
                m.mode = (k < 65) ? OP_EXEC : (k < 80) ? OP_DEL : OP_REPL;
                m.ref_id = live_refs[$urandom_range(live_refs.size() - 1)];
                if (k < 90)
                begin
                    m.share_count = 32'($urandom_range(1, 600));
                    m.limit_price = 32'(1000 + $urandom_range(80));
                    m.replacement_id = 64'($urandom_range(5000));
                end
            end
            if (n > count - 150)
                quiet = 1'b1;
            send_msg(m);
        end
    endtask

    initial
    begin
        errors = 0;
        idle_cycles = 0;
        quiet = 1'b0;
        rst_n = 1'b0;
        msg_valid = 1'b0;
        msg = '0;
        for (int s = 0; s < 2; s++)
            lvl_cnt[s] = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_level_full();
        test_random(1000);
        msg_valid <= 1'b0;
        while (top_of_book_q.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
